FILE: rtl/acsq_pkg.sv
// Shared types, constants and codes for the alarm clock sorted queue.
package acsq_pkg;

    localparam int ALARM_DEPTH = 16;
    localparam int IDX_W       = $clog2(ALARM_DEPTH);
    localparam int CNT_W       = $clog2(ALARM_DEPTH + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // input actions
    localparam logic [2:0] ACT_EVENT  = 3'd0;
    localparam logic [2:0] ACT_SET    = 3'd1;
    localparam logic [2:0] ACT_START  = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_REMOVE = 3'd4;

    // event classes
    localparam logic [1:0] CLS_ALARM = 2'd0;
    localparam logic [1:0] CLS_INPUT = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NO_SLIP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_IN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TPS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_ID = 3'd4;

    // datapath commands
    typedef struct packed {
        logic capture;     // latch input item
        logic mul;         // elapsed * units, load divider
        logic div_step;    // one quotient bit
        logic scale_done;  // form scaled time
        logic ev_prep;     // apply reset-on-input, set scan time
        logic ev_idle;     // no due alarm: current_time = t
        logic pop;         // pop head and emit record
        logic ev_end;      // final time update, reload next_due
        logic set_fail;    // set alarm refused, store full
        logic set_scan;    // insert: compare one entry
        logic set_shift;   // insert: move one entry up
        logic set_write;   // insert: write new entry
        logic rm_step;     // removal: one entry
        logic rm_end;      // removal done
        logic start;       // start clock
        logic stop;        // stop clock
        logic status;      // emit status result
    } t_cmd;

    typedef struct packed {
        logic div_last;    // final quotient bit
        logic running;
        logic ev_due;      // scan time reached next_due
        logic head_due;    // store not empty and head is due
        logic full;        // store full
        logic scan_more;   // insert scan continues
        logic shift_more;  // insert shift continues
        logic rm_more;     // removal continues
    } t_sts;

endpackage

FILE: rtl/alarm_clock_sorted_queue.sv
// Top level of the alarm clock sorted queue: configuration registers and units.
// An item is taken at a rising edge with start high and busy low. Busy drops in
// the cycle that carries the status result (last=1), so the next item can be
// taken at the edge that ends it. Start, stop and unused actions go straight to
// the status result; removal steps through every stored alarm. Command events
// and set alarms run the bit-serial scaling divider first. A non-alarm event
// on a running clock that reaches next_due then pops each due alarm, and an
// accepted set scans and shifts the stored alarms to insert the new entry.
// Alarm records come one per cycle ahead of the status result.
// Results cannot be held off; the receiver must take each one as it is strobed.
module alarm_clock_sorted_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [acsq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    input  logic [2:0]                          i_action,
    input  logic [31:0]                         i_now_ticks,
    input  logic [1:0]                          i_event_class,
    input  logic [30:0]                         i_delay,
    input  logic [15:0]                         i_owner,
    input  logic signed [31:0]                  i_user_word,
    input  logic                                i_from_live_time,
    input  logic [31:0]                         i_start_time,
    output logic                                o_valid,
    output logic                                o_kind,
    output logic [15:0]                         o_alarm_owner,
    output logic [31:0]                         o_alarm_time,
    output logic signed [31:0]                  o_alarm_user_word,
    output logic [15:0]                         o_source_clock,
    output logic [31:0]                         o_clock_time,
    output logic [31:0]                         o_lag,
    output logic                                o_ok,
    output logic                                o_last
);
    import acsq_pkg::*;

    logic        r_no_slip, r_reset_in;
    logic [15:0] r_tps, r_ups, r_clock_id;
    t_cmd        cmd;
    t_sts        sts;

    assign o_cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_slip  <= 1'b0;
            r_reset_in <= 1'b0;
            r_tps      <= 16'd1000;
            r_ups      <= 16'd60;
            r_clock_id <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NO_SLIP:  r_no_slip  <= i_cfg_data[0];
                REG_RESET_IN: r_reset_in <= i_cfg_data[0];
                REG_TPS:      r_tps      <= i_cfg_data;
                REG_UPS:      r_ups      <= i_cfg_data;
                REG_CLOCK_ID: r_clock_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acsq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_event_class (i_event_class),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    acsq_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_no_slip          (r_no_slip),
        .i_reset_on_input   (r_reset_in),
        .i_ticks_per_second (r_tps),
        .i_units_per_second (r_ups),
        .i_clock_id         (r_clock_id),
        .i_event_class      (i_event_class),
        .i_now_ticks        (i_now_ticks),
        .i_delay            (i_delay),
        .i_owner            (i_owner),
        .i_user_word        (i_user_word),
        .i_from_live_time   (i_from_live_time),
        .i_start_time       (i_start_time),
        .o_valid            (o_valid),
        .o_kind             (o_kind),
        .o_alarm_owner      (o_alarm_owner),
        .o_alarm_time       (o_alarm_time),
        .o_alarm_user_word  (o_alarm_user_word),
        .o_source_clock     (o_source_clock),
        .o_clock_time       (o_clock_time),
        .o_lag              (o_lag),
        .o_ok               (o_ok),
        .o_last             (o_last)
    );
endmodule

FILE: rtl/acsq_ctrl.sv
// Controller state machine of the alarm clock sorted queue.
module acsq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [2:0]     i_action,
    input  logic [1:0]     i_event_class,
    input  acsq_pkg::t_sts i_sts,
    output acsq_pkg::t_cmd o_cmd
);
    import acsq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_MUL   = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_SCALE = 11'b00000001000,
        S_DISP  = 11'b00000010000,
        S_EVCHK = 11'b00000100000,
        S_POP   = 11'b00001000000,
        S_SCAN  = 11'b00010000000,
        S_SHIFT = 11'b00100000000,
        S_RM    = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_act, n_act;
    logic [1:0] r_cls, n_cls;

    // next-state and command decode
    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_cls   = r_cls;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_act = i_action;
                    n_cls = i_event_class;
                    case (i_action)
                        ACT_EVENT:  n_state = S_MUL;
                        ACT_SET:    n_state = S_MUL;
                        ACT_REMOVE: n_state = S_RM;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale_done = 1'b1;
                n_state = S_DISP;
            end
            S_DISP: begin
                if (r_act == ACT_EVENT) begin
                    if (!i_sts.running || r_cls == CLS_ALARM) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.ev_prep = 1'b1;
                        n_state = S_EVCHK;
                    end
                end else begin
                    if (i_sts.full) begin
                        o_cmd.set_fail = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.set_scan = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            // next_due is only compared once, before the first pop
            S_EVCHK: begin
                if (!i_sts.ev_due) begin
                    o_cmd.ev_idle = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_sts.head_due) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    o_cmd.ev_end = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_more) o_cmd.set_scan = 1'b1;
                else n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_sts.shift_more) o_cmd.set_shift = 1'b1;
                else begin
                    o_cmd.set_write = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_RM: begin
                if (i_sts.rm_more) o_cmd.rm_step = 1'b1;
                else begin
                    o_cmd.rm_end = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.status = 1'b1;
                o_cmd.start  = (r_act == ACT_START);
                o_cmd.stop   = (r_act == ACT_STOP);
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_STOP;
            r_cls   <= CLS_ALARM;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
            r_cls   <= n_cls;
        end
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTH
    // a status result only comes from the final state
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.status |=> (r_state == S_IDLE))
        else $error("status not followed by idle");
    // pops only happen during event processing
    a_pop_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> (r_act == ACT_EVENT))
        else $error("pop outside event");
    // insert writes only for set alarm
    a_write_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.set_write |-> (r_act == ACT_SET))
        else $error("write outside set");
`endif
endmodule

FILE: rtl/acsq_dp.sv
// Datapath of the alarm clock sorted queue: scaling, alarm store, results.
module acsq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  acsq_pkg::t_cmd                  i_cmd,
    output acsq_pkg::t_sts                  o_sts,
    input  logic                            i_no_slip,
    input  logic                            i_reset_on_input,
    input  logic [15:0]                     i_ticks_per_second,
    input  logic [15:0]                     i_units_per_second,
    input  logic [15:0]                     i_clock_id,
    input  logic [1:0]                      i_event_class,
    input  logic [31:0]                     i_now_ticks,
    input  logic [30:0]                     i_delay,
    input  logic [15:0]                     i_owner,
    input  logic signed [31:0]              i_user_word,
    input  logic                            i_from_live_time,
    input  logic [31:0]                     i_start_time,
    output logic                            o_valid,
    output logic                            o_kind,
    output logic [15:0]                     o_alarm_owner,
    output logic [31:0]                     o_alarm_time,
    output logic signed [31:0]              o_alarm_user_word,
    output logic [15:0]                     o_source_clock,
    output logic [31:0]                     o_clock_time,
    output logic [31:0]                     o_lag,
    output logic                            o_ok,
    output logic                            o_last
);
    import acsq_pkg::*;

    // latched input item
    logic [1:0]  r_cls;
    logic [31:0] r_now, r_start;
    logic [30:0] r_delay;
    logic [15:0] r_owner;
    logic [31:0] r_word;
    logic        r_live;

    // clock state
    logic [31:0] r_time_base, r_cur, r_ticks_base, r_next_due;
    logic        r_running;
    logic [CNT_W-1:0] r_count;

    // scaling unit
    logic [15:0] r_rem;      // partial remainder
    logic [15:0] r_div;
    logic [47:0] r_quo;      // dividend shifting out, quotient shifting in
    logic [5:0]  r_step;
    logic [31:0] r_t;        // scaled / scan time

    // alarm store
    logic [31:0] r_due  [ALARM_DEPTH];
    logic [15:0] r_own  [ALARM_DEPTH];
    logic [31:0] r_wrd  [ALARM_DEPTH];

    // insert / removal pointers
    logic [CNT_W-1:0] r_pos, r_rd, r_wr;
    logic [31:0]      r_new_due;
    logic             r_fail;
    logic             r_scan_go;   // insert scan under way

    // result register
    logic        r_valid, r_kind, r_ok, r_last;
    logic [15:0] r_o_own;
    logic [31:0] r_o_time, r_o_word, r_o_lag;

    logic [31:0] elapsed, base, due_calc, dly, pop_t;
    logic [16:0] trial;
    logic [15:0] divisor;

    assign elapsed  = r_now - r_ticks_base;
    assign divisor  = (i_ticks_per_second == 16'd0) ? 16'd1 : i_ticks_per_second;
    assign trial    = {r_rem, r_quo[47]} - {1'b0, r_div};
    assign dly      = (r_delay == 31'd0) ? 32'd1 : {1'b0, r_delay};
    assign base     = r_live ? r_t : r_cur;
    assign due_calc = base + dly;
    assign pop_t    = (r_t > r_due[0] && !i_no_slip) ? r_due[0] : r_t;

    // status to the controller
    always_comb begin
        o_sts.div_last   = (r_step == 6'd47);
        o_sts.running    = r_running;
        o_sts.ev_due     = (r_t >= r_next_due);
        o_sts.head_due   = (r_count != '0) && (r_due[0] <= r_t);
        o_sts.full       = (r_count >= CNT_W'(ALARM_DEPTH));
        o_sts.scan_more  = (r_pos < r_count) && (r_due[r_pos[IDX_W-1:0]] < r_new_due);
        o_sts.shift_more = (r_wr > r_pos);
        o_sts.rm_more    = (r_rd < r_count);
    end

    // input capture and scaling: restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cls   <= i_event_class;
            r_now   <= i_now_ticks;
            r_start <= i_start_time;
            r_delay <= i_delay;
            r_owner <= i_owner;
            r_word  <= i_user_word;
            r_live  <= i_from_live_time;
        end
        if (i_cmd.mul) begin
            r_quo  <= elapsed * i_units_per_second;
            r_rem  <= '0;
            r_div  <= divisor;
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            if (!trial[16]) begin
                r_rem <= trial[15:0];
                r_quo <= {r_quo[46:0], 1'b1};
            end else begin
                r_rem <= {r_rem[14:0], r_quo[47]};
                r_quo <= {r_quo[46:0], 1'b0};
            end
            r_step <= r_step + 6'd1;
        end
        if (i_cmd.scale_done) r_t <= r_time_base + r_quo[31:0];
        if (i_cmd.ev_prep && i_reset_on_input && r_cls == CLS_INPUT) r_t <= '0;
        if (i_cmd.pop && r_t > r_due[0] && !i_no_slip) r_t <= r_due[0];
        if (i_cmd.set_scan && !r_scan_go) r_new_due <= due_calc;
    end

    // first scan command forms the new due time, later ones advance the position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_scan_go <= 1'b0;
        else if (i_cmd.scale_done) r_scan_go <= 1'b0;
        else if (i_cmd.set_scan) r_scan_go <= 1'b1;
    end

    // clock state and store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_base  <= '0;
            r_cur        <= '0;
            r_ticks_base <= '0;
            r_next_due   <= ALL_ONES;
            r_running    <= 1'b0;
            r_count      <= '0;
            r_pos        <= '0;
            r_rd         <= '0;
            r_wr         <= '0;
            r_fail       <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_pos  <= '0;
                r_rd   <= '0;
                r_wr   <= '0;
                r_fail <= 1'b0;
            end
            if (i_cmd.set_fail) r_fail <= 1'b1;
            if (i_cmd.start) begin
                r_time_base  <= r_start;
                r_cur        <= r_start;
                r_ticks_base <= r_now;
                r_running    <= 1'b1;
            end
            if (i_cmd.stop) r_running <= 1'b0;
            if (i_cmd.ev_prep && i_reset_on_input && r_cls == CLS_INPUT) begin
                r_ticks_base <= r_now;
                r_time_base  <= '0;
            end
            if (i_cmd.ev_idle) r_cur <= r_t;
            if (i_cmd.pop) begin
                for (int i = 0; i < ALARM_DEPTH - 1; i++) begin
                    r_due[i] <= r_due[i+1];
                    r_own[i] <= r_own[i+1];
                    r_wrd[i] <= r_wrd[i+1];
                end
                r_count    <= r_count - CNT_W'(1);
                r_cur      <= r_due[0];
                r_next_due <= ALL_ONES;
                if (r_t > r_due[0] && !i_no_slip) begin
                    r_time_base  <= r_due[0];
                    r_ticks_base <= r_now;
                end
            end
            if (i_cmd.ev_end) begin
                r_cur      <= r_t;
                r_next_due <= (r_count == '0) ? ALL_ONES : r_due[0];
            end
            if (i_cmd.set_scan) begin
                if (r_scan_go) r_pos <= r_pos + CNT_W'(1);
                r_wr <= r_count;
            end
            if (i_cmd.set_shift) begin
                r_due[r_wr[IDX_W-1:0]] <= r_due[r_wr[IDX_W-1:0] - IDX_W'(1)];
                r_own[r_wr[IDX_W-1:0]] <= r_own[r_wr[IDX_W-1:0] - IDX_W'(1)];
                r_wrd[r_wr[IDX_W-1:0]] <= r_wrd[r_wr[IDX_W-1:0] - IDX_W'(1)];
                r_wr <= r_wr - CNT_W'(1);
            end
            if (i_cmd.set_write) begin
                r_due[r_pos[IDX_W-1:0]] <= r_new_due;
                r_own[r_pos[IDX_W-1:0]] <= r_owner;
                r_wrd[r_pos[IDX_W-1:0]] <= r_word;
                r_count <= r_count + CNT_W'(1);
                if (r_next_due > r_new_due) r_next_due <= r_new_due;
            end
            if (i_cmd.rm_step) begin
                if (r_own[r_rd[IDX_W-1:0]] != r_owner) begin
                    r_due[r_wr[IDX_W-1:0]] <= r_due[r_rd[IDX_W-1:0]];
                    r_own[r_wr[IDX_W-1:0]] <= r_own[r_rd[IDX_W-1:0]];
                    r_wrd[r_wr[IDX_W-1:0]] <= r_wrd[r_rd[IDX_W-1:0]];
                    r_wr <= r_wr + CNT_W'(1);
                end
                r_rd <= r_rd + CNT_W'(1);
            end
            if (i_cmd.rm_end) r_count <= r_wr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.pop || i_cmd.status;
        end
        if (i_cmd.pop) begin
            r_kind   <= 1'b1;
            r_o_own  <= r_own[0];
            r_o_time <= r_due[0];
            r_o_word <= r_wrd[0];
            r_o_lag  <= pop_t - r_due[0];
            r_ok     <= 1'b1;
            r_last   <= 1'b0;
        end else if (i_cmd.status) begin
            r_kind   <= 1'b0;
            r_o_own  <= '0;
            r_o_time <= '0;
            r_o_word <= '0;
            r_o_lag  <= '0;
            r_ok     <= !r_fail;
            r_last   <= 1'b1;
        end
    end

    assign o_valid           = r_valid;
    assign o_kind            = r_kind;
    assign o_alarm_owner     = r_o_own;
    assign o_alarm_time      = r_o_time;
    assign o_alarm_user_word = r_o_word;
    assign o_source_clock    = i_clock_id;
    assign o_clock_time      = r_cur;
    assign o_lag             = r_o_lag;
    assign o_ok              = r_ok;
    assign o_last            = r_last;

`ifndef SYNTH
    // the count never exceeds the store depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ALARM_DEPTH))
        else $error("alarm count overflow");
    // a pop always lowers the count by one
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop count mismatch");
    // a write never happens on a full store
    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_write |-> (r_count < CNT_W'(ALARM_DEPTH)))
        else $error("write into full store");
`endif
endmodule
